/* rtl/arat_pkg.sv */
// Shared types and constants for the adaptive readahead trigger.
// No dependencies; imported by arat_core and adaptive_readahead_trigger_top.
package arat_pkg;

  localparam int WINDOW_BITS_DEF = 10;

  localparam logic [2:0] FUNC_NEXT_REC  = 3'd0;
  localparam logic [2:0] FUNC_PREV_REC  = 3'd1;
  localparam logic [2:0] FUNC_NEXT_PAGE = 3'd2;
  localparam logic [2:0] FUNC_PREV_PAGE = 3'd3;
  localparam logic [2:0] FUNC_JUMP      = 3'd4;

  localparam logic [1:0] PH_INIT = 2'd0;
  localparam logic [1:0] PH_PF   = 2'd1;
  localparam logic [1:0] PH_ALL  = 2'd2;
  localparam logic [1:0] PH_STOP = 2'd3;

  localparam logic [1:0] DIR_UNSET = 2'd0;
  localparam logic [1:0] DIR_FWD   = 2'd1;
  localparam logic [1:0] DIR_BWD   = 2'd2;

  localparam logic [2:0] CFG_CONSUMER_GAP   = 3'd0;
  localparam logic [2:0] CFG_PAGE_ENTRY_GAP = 3'd1;
  localparam logic [2:0] CFG_WINDOW_MIN     = 3'd2;
  localparam logic [2:0] CFG_WINDOW_GROWTH  = 3'd3;
  localparam logic [2:0] CFG_WINDOW_MAX     = 3'd4;

  localparam logic [9:0]  CONSUMER_GAP_RST   = 10'd2;
  localparam logic [15:0] PAGE_ENTRY_GAP_RST = 16'd4;
  localparam logic [9:0]  WINDOW_MIN_RST     = 10'd4;
  localparam logic [4:0]  WINDOW_GROWTH_RST  = 5'd2;
  localparam logic [9:0]  WINDOW_MAX_RST     = 10'd64;

  typedef struct packed {
    logic [9:0]  consumer_gap;
    logic [15:0] page_entry_gap;
    logic [9:0]  window_min;
    logic [4:0]  window_growth;
    logic [9:0]  window_max;
  } cfg_t;

  typedef struct packed {
    logic [2:0]  func;
    logic        prefetch_enabled;
    logic        path_valid;
    logic [15:0] entries_ahead;
  } event_t;

  typedef struct packed {
    logic       result_code;
    logic       fetch_start;
    logic [9:0] fetch_pages;
    logic       fetch_backward;
    logic       relocate;
  } result_t;

endpackage

/* rtl/adaptive_readahead_trigger_top.sv */
// Adaptive readahead trigger: an accepted beat's result is registered before out_valid.
// Throughput one beat per cycle while in_stall is low.
// A two-entry result queue lets in_ accept while a result waits on out_stall.
// rst_n is synchronous: state to initial, registers to defaults, queue empty.
// Depends on arat_pkg and arat_core.
module adaptive_readahead_trigger_top #(
  parameter int WINDOW_BITS = arat_pkg::WINDOW_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_wdata,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  in_func,
  input  logic        in_prefetch_enabled,
  input  logic        in_path_valid,
  input  logic [15:0] in_entries_ahead,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_result_code,
  output logic        out_fetch_start,
  output logic [9:0]  out_fetch_pages,
  output logic        out_fetch_backward,
  output logic        out_relocate
);
  import arat_pkg::*;

  cfg_t    cfg_r;
  event_t  ev;
  result_t res;
  result_t head_r, skid_r;
  logic    head_v_r, skid_v_r;
  logic    push, pop;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.consumer_gap   <= CONSUMER_GAP_RST;
      cfg_r.page_entry_gap <= PAGE_ENTRY_GAP_RST;
      cfg_r.window_min     <= WINDOW_MIN_RST;
      cfg_r.window_growth  <= WINDOW_GROWTH_RST;
      cfg_r.window_max     <= WINDOW_MAX_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_CONSUMER_GAP:   cfg_r.consumer_gap   <= cfg_wdata[9:0];
        CFG_PAGE_ENTRY_GAP: cfg_r.page_entry_gap <= cfg_wdata;
        CFG_WINDOW_MIN:     cfg_r.window_min     <= cfg_wdata[9:0];
        CFG_WINDOW_GROWTH:  cfg_r.window_growth  <= cfg_wdata[4:0];
        CFG_WINDOW_MAX:     cfg_r.window_max     <= cfg_wdata[9:0];
        default: ;
      endcase
    end
  end

  assign ev.func             = in_func;
  assign ev.prefetch_enabled = in_prefetch_enabled;
  assign ev.path_valid       = in_path_valid;
  assign ev.entries_ahead    = in_entries_ahead;

  assign in_stall = skid_v_r;
  assign push     = in_valid && !in_stall;
  assign pop      = head_v_r && !out_stall;

  arat_core #(
    .WINDOW_BITS(WINDOW_BITS)
  ) u_core (
    .clk      (clk),
    .rst_n    (rst_n),
    .ev_accept(push),
    .ev       (ev),
    .cfg      (cfg_r),
    .res      (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_v_r <= 1'b0;
      skid_v_r <= 1'b0;
    end else if (!head_v_r || pop) begin
      if (skid_v_r) begin
        head_v_r <= 1'b1;
        skid_v_r <= push;
      end else begin
        head_v_r <= push;
      end
    end else if (push) begin
      skid_v_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!head_v_r || pop) begin
      if (skid_v_r) begin
        head_r <= skid_r;
        if (push) begin
          skid_r <= res;
        end
      end else if (push) begin
        head_r <= res;
      end
    end else if (push) begin
      skid_r <= res;
    end
  end

  assign out_valid          = head_v_r;
  assign out_result_code    = head_r.result_code;
  assign out_fetch_start    = head_r.fetch_start;
  assign out_fetch_pages    = head_r.fetch_pages;
  assign out_fetch_backward = head_r.fetch_backward;
  assign out_relocate       = head_r.relocate;

endmodule

/* rtl/arat_core.sv */
// Decision logic and cursor state of the adaptive readahead trigger.
// Depends on arat_pkg; one event is resolved per accepted beat.
module arat_core #(
  parameter int WINDOW_BITS = arat_pkg::WINDOW_BITS_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             ev_accept,
  input  arat_pkg::event_t ev,
  input  arat_pkg::cfg_t   cfg,
  output arat_pkg::result_t res
);
  import arat_pkg::*;

  localparam int PW   = WINDOW_BITS + 5;
  localparam int CW   = (PW > 10) ? PW : 10;
  localparam int EW   = (WINDOW_BITS > 10) ? WINDOW_BITS : 10;
  localparam int SUMW = 17;
  localparam logic [CW-1:0] LIMIT = CW'((1 << WINDOW_BITS) - 1);

  logic [1:0]             phase_r, phase_nxt;
  logic                   active_r, active_nxt;
  logic [1:0]             dir_r, dir_nxt;
  logic [15:0]            pages_r, pages_nxt;
  logic [WINDOW_BITS-1:0] window_r, window_nxt;

  logic                   qual;
  logic [1:0]             dir_w;
  logic [1:0]             ph_w;
  logic [15:0]            pr_w;
  logic [WINDOW_BITS-1:0] wp_w;
  logic                   fetch_w;
  logic [PW-1:0]          prod_w;
  logic [CW-1:0]          cand_w;
  logic [WINDOW_BITS-1:0] grown_w;
  logic [EW-1:0]          grown_ext;

  assign qual   = ev.prefetch_enabled & ev.path_valid;
  assign dir_w  = ev.func[0] ? DIR_BWD : DIR_FWD;
  assign prod_w = PW'(wp_w) * PW'(cfg.window_growth);

  always_comb begin
    if (wp_w == '0) begin
      cand_w = CW'(cfg.window_min);
    end else if (CW'(prod_w) > CW'(cfg.window_max)) begin
      cand_w = CW'(cfg.window_max);
    end else begin
      cand_w = CW'(prod_w);
    end
    if (cand_w > LIMIT) begin
      grown_w = LIMIT[WINDOW_BITS-1:0];
    end else begin
      grown_w = cand_w[WINDOW_BITS-1:0];
    end
  end

  assign grown_ext = EW'(grown_w);

  always_comb begin
    phase_nxt  = phase_r;
    active_nxt = active_r;
    dir_nxt    = dir_r;
    pages_nxt  = pages_r;
    window_nxt = window_r;
    res        = '0;
    ph_w       = phase_r;
    pr_w       = pages_r;
    wp_w       = window_r;
    fetch_w    = 1'b0;
    if (ev.func == FUNC_JUMP) begin
      phase_nxt  = PH_INIT;
      active_nxt = 1'b1;
      dir_nxt    = DIR_UNSET;
      pages_nxt  = '0;
      window_nxt = '0;
    end else if (ev.func < FUNC_JUMP) begin
      if (!qual) begin
        active_nxt = 1'b0;
        phase_nxt  = PH_STOP;
        res.result_code = 1'b1;
      end else if (!active_r) begin
        res.result_code = 1'b1;
      end else if (phase_r != PH_ALL) begin
        if (dir_r != DIR_UNSET && dir_r != dir_w) begin
          ph_w = PH_INIT;
          pr_w = '0;
          wp_w = '0;
        end
        if (ev.func[1] && pr_w != 16'hFFFF) begin
          pr_w = pr_w + 16'd1;
        end
        fetch_w = SUMW'(wp_w) <= SUMW'(pr_w) + SUMW'(cfg.consumer_gap);
        if (ph_w == PH_INIT && ev.entries_ahead < cfg.page_entry_gap) begin
          fetch_w = 1'b1;
        end
        dir_nxt    = dir_w;
        phase_nxt  = ph_w;
        pages_nxt  = pr_w;
        window_nxt = wp_w;
        if (fetch_w) begin
          res.fetch_start    = 1'b1;
          res.fetch_pages    = grown_ext[9:0];
          res.fetch_backward = (dir_w == DIR_BWD);
          res.relocate       = (ph_w == PH_PF) || (ph_w == PH_ALL);
          phase_nxt  = PH_PF;
          pages_nxt  = '0;
          window_nxt = grown_w;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_INIT;
      active_r <= 1'b1;
      dir_r    <= DIR_UNSET;
      pages_r  <= '0;
      window_r <= '0;
    end else if (ev_accept) begin
      phase_r  <= phase_nxt;
      active_r <= active_nxt;
      dir_r    <= dir_nxt;
      pages_r  <= pages_nxt;
      window_r <= window_nxt;
    end
  end

`ifndef SYNTHESIS
  a_off_no_fetch: assert property (@(posedge clk) disable iff (!rst_n)
    res.result_code |-> !res.fetch_start)
    else $error("fetch issued while switched off");
  a_reloc_fetch: assert property (@(posedge clk) disable iff (!rst_n)
    res.relocate |-> res.fetch_start)
    else $error("relocate without fetch");
  a_off_stopped: assert property (@(posedge clk) disable iff (!rst_n)
    !active_r |-> phase_r == PH_STOP)
    else $error("inactive controller not stopped");
  a_jump_clears: assert property (@(posedge clk) disable iff (!rst_n)
    ev_accept && ev.func == FUNC_JUMP |=>
      active_r && phase_r == PH_INIT && pages_r == '0 && window_r == '0)
    else $error("jump did not clear state");
`endif

endmodule

/* bench/tb.sv */
`timescale 1ns / 100ps
// Self-checking bench for adaptive_readahead_trigger_top: cursor events in, fetch decisions out.
// Needs arat_pkg and the RTL; a scoreboard class tracks each cursor event and its decision.
module tb;
  import arat_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int WIN_LIMIT = (1 << WINDOW_BITS_DEF) - 1;

  class readahead_scoreboard;
    cfg_t        cfg;
    logic [1:0]  phase;
    logic        active;
    logic [1:0]  travel_dir;
    logic [15:0] pages_read;
    logic [9:0]  window_pages;
    result_t     pending_decisions[$];
    int          mismatches;
    int          events_seen;
    int          fetches_seen;

    function new();
      cfg.consumer_gap   = CONSUMER_GAP_RST;
      cfg.page_entry_gap = PAGE_ENTRY_GAP_RST;
      cfg.window_min     = WINDOW_MIN_RST;
      cfg.window_growth  = WINDOW_GROWTH_RST;
      cfg.window_max     = WINDOW_MAX_RST;
      restart_cursor();
      mismatches = 0;
      events_seen = 0;
      fetches_seen = 0;
    endfunction

    function void restart_cursor();
      phase        = PH_INIT;
      active       = 1'b1;
      travel_dir   = DIR_UNSET;
      pages_read   = '0;
      window_pages = '0;
    endfunction

    function void write_register(logic [2:0] idx, logic [15:0] value);
      case (idx)
        CFG_CONSUMER_GAP:   cfg.consumer_gap   = value[9:0];
        CFG_PAGE_ENTRY_GAP: cfg.page_entry_gap = value;
        CFG_WINDOW_MIN:     cfg.window_min     = value[9:0];
        CFG_WINDOW_GROWTH:  cfg.window_growth  = value[4:0];
        CFG_WINDOW_MAX:     cfg.window_max     = value[9:0];
        default: ;
      endcase
    endfunction

    function void widen_window();
      int w;
      if (window_pages == 0) begin
        w = int'(cfg.window_min);
      end else begin
        w = int'(window_pages) * int'(cfg.window_growth);
        if (w > int'(cfg.window_max)) w = int'(cfg.window_max);
      end
      if (w > WIN_LIMIT) w = WIN_LIMIT;
      window_pages = w[9:0];
    endfunction

    function void note_event(event_t ev);
      result_t    r;
      logic [1:0] dir;
      bit         fire;
      r = '0;
      events_seen++;
      if (ev.func == FUNC_JUMP) begin
        restart_cursor();
      end else if (ev.func < FUNC_JUMP) begin
        if (!(ev.prefetch_enabled && ev.path_valid)) begin
          active = 1'b0;
          phase = PH_STOP;
        end
        if (!active) begin
          r.result_code = 1'b1;
        end else if (phase != PH_ALL) begin
          dir = ev.func[0] ? DIR_BWD : DIR_FWD;
          if (travel_dir != DIR_UNSET && travel_dir != dir) restart_cursor();
          travel_dir = dir;
          if (ev.func[1] && pages_read != 16'hFFFF) pages_read++;
          fire = int'(window_pages) <= int'(pages_read) + int'(cfg.consumer_gap);
          if (phase == PH_INIT && ev.entries_ahead < cfg.page_entry_gap) fire = 1'b1;
          if (fire) begin
            widen_window();
            r.fetch_start    = 1'b1;
            r.fetch_pages    = window_pages;
            r.fetch_backward = (dir == DIR_BWD);
            r.relocate       = (phase == PH_PF || phase == PH_ALL);
            phase = PH_PF;
            pages_read = '0;
            fetches_seen++;
          end
        end
      end
      pending_decisions.push_back(r);
    endfunction

    task report(string msg);
      mismatches++;
      $display("[%0t] MISMATCH: %s", $realtime, msg);
    endtask

    task compare_field(string name, logic [15:0] got, logic [15:0] want);
      if (got !== want) report($sformatf("%s got %0d expected %0d", name, got, want));
    endtask

    task check_result(result_t got);
      result_t want;
      if (pending_decisions.size() == 0) begin
        report("result beat with no decision outstanding");
        return;
      end
      want = pending_decisions.pop_front();
      compare_field("result_code", 16'(got.result_code), 16'(want.result_code));
      compare_field("fetch_start", 16'(got.fetch_start), 16'(want.fetch_start));
      compare_field("fetch_pages", 16'(got.fetch_pages), 16'(want.fetch_pages));
      compare_field("fetch_backward", 16'(got.fetch_backward), 16'(want.fetch_backward));
      compare_field("relocate", 16'(got.relocate), 16'(want.relocate));
    endtask
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_index = CFG_CONSUMER_GAP;
  logic [15:0] cfg_wdata = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [2:0]  in_func = FUNC_NEXT_REC;
  logic        in_prefetch_enabled = 1'b0;
  logic        in_path_valid = 1'b0;
  logic [15:0] in_entries_ahead = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        out_result_code;
  logic        out_fetch_start;
  logic [9:0]  out_fetch_pages;
  logic        out_fetch_backward;
  logic        out_relocate;

  readahead_scoreboard sb;
  int  idle_pct = 0;
  int  stall_pct = 0;
  int  stall_left = 0;
  int  cycles = 0;
  int  settings_used = 1;
  bit  heading_back = 1'b0;

  adaptive_readahead_trigger_top u_top (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_wdata          (cfg_wdata),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_func            (in_func),
    .in_prefetch_enabled(in_prefetch_enabled),
    .in_path_valid      (in_path_valid),
    .in_entries_ahead   (in_entries_ahead),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_result_code    (out_result_code),
    .out_fetch_start    (out_fetch_start),
    .out_fetch_pages    (out_fetch_pages),
    .out_fetch_backward (out_fetch_backward),
    .out_relocate       (out_relocate)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("adaptive_readahead_trigger_top test failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst_n || stall_pct == 0) begin
      out_stall <= 1'b0;
      stall_left <= 0;
    end else if (stall_left != 0) begin
      out_stall <= 1'b1;
      stall_left <= stall_left - 1;
    end else if ($urandom_range(0, 99) < stall_pct) begin
      out_stall <= 1'b1;
      stall_left <= $urandom_range(0, 16);
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin : result_monitor
    result_t got;
    if (rst_n && out_valid && !out_stall) begin
      got.result_code    = out_result_code;
      got.fetch_start    = out_fetch_start;
      got.fetch_pages    = out_fetch_pages;
      got.fetch_backward = out_fetch_backward;
      got.relocate       = out_relocate;
      sb.check_result(got);
    end
  end

  function automatic event_t mk_event(logic [2:0] func, logic pe, logic pv, logic [15:0] ahead);
    event_t ev;
    ev.func = func;
    ev.prefetch_enabled = pe;
    ev.path_valid = pv;
    ev.entries_ahead = ahead;
    return ev;
  endfunction

  function automatic event_t pick_event();
    event_t ev;
    int     roll;
    int     peg;
    roll = $urandom_range(0, 99);
    if (!sb.active && $urandom_range(0, 3) == 0) roll = 0;
    ev.prefetch_enabled = 1'b1;
    ev.path_valid = 1'b1;
    if ($urandom_range(0, 99) < 3) begin
      ev.prefetch_enabled = 1'($urandom_range(0, 1));
      ev.path_valid = 1'($urandom_range(0, 1));
    end
    if (roll < 3) begin
      ev.func = FUNC_JUMP;
    end else if (roll < 5) begin
      ev.func = 3'($urandom_range(FUNC_JUMP + 1, 3'd7));
    end else begin
      if ($urandom_range(0, 99) < 5) heading_back = !heading_back;
      ev.func = (roll < 75) ? FUNC_NEXT_PAGE : FUNC_NEXT_REC;
      ev.func[0] = heading_back;
    end
    peg = int'(sb.cfg.page_entry_gap);
    case ($urandom_range(0, 2))
      0: ev.entries_ahead = 16'($urandom_range(0, 15));
      1: ev.entries_ahead = 16'($urandom_range(peg > 2 ? peg - 2 : 0,
                                               peg < 65533 ? peg + 2 : 65535));
      default: ev.entries_ahead = 16'($urandom_range(0, 65535));
    endcase
    return ev;
  endfunction

  task send_event(event_t ev);
    if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
    in_valid            <= 1'b1;
    in_func             <= ev.func;
    in_prefetch_enabled <= ev.prefetch_enabled;
    in_path_valid       <= ev.path_valid;
    in_entries_ahead    <= ev.entries_ahead;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_event(ev);
  endtask

  task drain();
    while (sb.pending_decisions.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task write_reg(logic [2:0] idx, logic [15:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    sb.write_register(idx, value);
    @(posedge clk);
  endtask

  task apply_settings(logic [15:0] cg, logic [15:0] peg, logic [15:0] wmin,
                      logic [15:0] grow, logic [15:0] wmax);
    write_reg(CFG_CONSUMER_GAP, cg);
    write_reg(CFG_PAGE_ENTRY_GAP, peg);
    write_reg(CFG_WINDOW_MIN, wmin);
    write_reg(CFG_WINDOW_GROWTH, grow);
    write_reg(CFG_WINDOW_MAX, wmax);
    cfg_we <= 1'b0;
    @(posedge clk);
    settings_used++;
  endtask

  task apply_random_settings();
    logic [15:0] cg, peg, wmin, grow, wmax;
    cg   = 16'(($urandom_range(0, 9) == 0) ? $urandom_range(0, 1023) : $urandom_range(0, 6));
    peg  = 16'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 65535) : $urandom_range(0, 40));
    wmin = 16'($urandom_range(1, 10));
    grow = 16'(($urandom_range(0, 9) == 0) ? $urandom_range(0, 31) : $urandom_range(1, 4));
    wmax = 16'(($urandom_range(0, 4) == 0) ? 1023 : $urandom_range(1, 120));
    apply_settings(cg, peg, wmin, grow, wmax);
  endtask

  task run_random(int count, int pct, int pause_at);
    idle_pct = pct;
    stall_pct = pct;
    for (int i = 0; i < count; i++) begin
      if (i == pause_at) begin
        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.pending_decisions.size() != 0) @(posedge clk);
      end
      send_event(pick_event());
    end
    in_valid <= 1'b0;
    drain();
  endtask

  task directed_part();
    idle_pct = 20;
    stall_pct = 20;
    send_event(mk_event(FUNC_NEXT_REC, 1'b1, 1'b1, 16'd0));
    send_event(mk_event(FUNC_NEXT_REC, 1'b1, 1'b1, 16'hFFFF));
    send_event(mk_event(FUNC_NEXT_PAGE, 1'b1, 1'b1, 16'd100));
    send_event(mk_event(FUNC_NEXT_PAGE, 1'b1, 1'b1, 16'd100));
    send_event(mk_event(FUNC_PREV_REC, 1'b1, 1'b1, 16'd3));
    send_event(mk_event(FUNC_PREV_PAGE, 1'b1, 1'b1, 16'hFFFF));
    send_event(mk_event(FUNC_PREV_PAGE, 1'b1, 1'b1, 16'h5555));
    for (int f = FUNC_JUMP + 1; f < 8; f++)
      send_event(mk_event(3'(f), f[0], f[1], 16'hAAAA));
    send_event(mk_event(FUNC_PREV_REC, 1'b0, 1'b1, 16'd0));
    send_event(mk_event(FUNC_NEXT_PAGE, 1'b1, 1'b1, 16'd0));
    send_event(mk_event(FUNC_JUMP, 1'b0, 1'b0, 16'd0));
    send_event(mk_event(FUNC_NEXT_PAGE, 1'b1, 1'b0, 16'd0));
    send_event(mk_event(FUNC_JUMP, 1'b1, 1'b1, 16'hFFFF));
    send_event(mk_event(FUNC_NEXT_PAGE, 1'b1, 1'b1, 16'hFFFF));
    repeat (8) send_event(mk_event(FUNC_NEXT_PAGE, 1'b1, 1'b1, 16'd0));
    in_valid <= 1'b0;
    drain();
  endtask

  initial begin
    sb = new();
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    directed_part();
    run_random(220, 15, 60);
    apply_settings(16'd0, 16'd0, 16'd1, 16'd16, 16'd1023);
    run_random(180, 25, -1);
    apply_settings(16'd1023, 16'hFFFF, 16'd1023, 16'd1, 16'd1);
    run_random(120, 10, -1);
    apply_settings(16'd3, 16'd100, 16'd0, 16'd0, 16'd500);
    run_random(150, 15, -1);
    repeat (3) begin
      apply_random_settings();
      run_random(130, $urandom_range(0, 1) ? 20 : 0, -1);
    end
    apply_random_settings();
    run_random(130, 0, -1);
    repeat (8) @(posedge clk);
    if (sb.pending_decisions.size() != 0)
      sb.report($sformatf("%0d decisions never arrived", sb.pending_decisions.size()));
    $display("Covered %0d cursor events under %0d register settings, %0d prefetch requests.",
             sb.events_seen, settings_used, sb.fetches_seen);
    if (sb.mismatches == 0) begin
      $display("adaptive_readahead_trigger_top test passed");
    end else begin
      $display("adaptive_readahead_trigger_top test failed");
    end
    $finish;
  end

endmodule
